// ----- rtl/sha256_ctr_keystream_xor_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef SHA256_CTR_KEYSTREAM_XOR_TOP_ASSERT_SVH
`define SHA256_CTR_KEYSTREAM_XOR_TOP_ASSERT_SVH
// Assert a property on clk, disabled while reset is low.
`define SCK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Assert that a result signal holds while the output word waits.
`define SCK_HOLD_STABLE(label, sig, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) \
        m_axis_tvalid && !m_axis_tready |=> $stable(sig)) else $error(msg);
`endif

// ----- rtl/sck_pkg.sv -----
// ----------------------------------------------------------------------------
// sck_pkg
// Shared types, constants and round functions of the SHA-256 keystream block.
// ----------------------------------------------------------------------------
`default_nettype none
package sck_pkg;
    localparam int BlockBytes = 32;
    localparam int QueueDepth = 2;
    localparam logic [2:0] RegKeyW0 = 3'd0;
    localparam logic [2:0] RegKeyW1 = 3'd1;
    localparam logic [2:0] RegKeyW2 = 3'd2;
    localparam logic [2:0] RegKeyW3 = 3'd3;
    localparam logic [2:0] RegNonceHi = 3'd4;
    localparam logic [2:0] RegNonceLo = 3'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
        logic       new_block;
        logic [4:0] pos;
        logic [31:0] count;
    } item_t;

    typedef enum logic [1:0] {ST_IDLE, ST_ROUND, ST_OUT} core_state_t;

    localparam logic [31:0] RoundK [64] = '{
        32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
        32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
        32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
        32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
        32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
        32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
        32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
        32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
        32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
        32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
        32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};

    localparam logic [31:0] InitH [8] = '{
        32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
        32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction
endpackage
`default_nettype wire

// ----- rtl/sck_front.sv -----
// ----------------------------------------------------------------------------
// sck_front
// Accepts input words, tracks block position and counter, tags new blocks.
// ----------------------------------------------------------------------------
`default_nettype none
module sck_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          msg_start,
    input  wire logic          msg_end,
    output logic               q_valid,
    input  wire logic          q_ready,
    output sck_pkg::item_t     q_item
);
    logic [4:0]  pos_reg, pos_next;
    logic [31:0] count_reg, count_next;
    logic [4:0]  pos_use;
    logic [31:0] count_use;
    logic        fire;

    assign in_ready = q_ready;
    assign q_valid  = in_valid;
    assign fire     = in_valid && q_ready;
    assign pos_use   = msg_start ? 5'd0 : pos_reg;
    assign count_use = msg_start ? 32'd0 : count_reg;

    always_comb
    begin
        q_item.data_byte = data_byte;
        q_item.last      = msg_end;
        q_item.new_block = (pos_use == 5'd0);
        q_item.pos       = pos_use;
        q_item.count     = count_use;
        pos_next   = pos_reg;
        count_next = count_reg;
        if (fire)
        begin
            if (msg_end)
            begin
                pos_next   = 5'd0;
                count_next = 32'd0;
            end
            else
            begin
                pos_next   = pos_use + 5'd1;
                count_next = (pos_use == 5'd31) ? count_use + 32'd1 : count_use;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= 5'd0;
            count_reg <= 32'd0;
        end
        else
        begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/sck_queue.sv -----
// ----------------------------------------------------------------------------
// sck_queue
// Short FIFO between the front and the keystream core.
// ----------------------------------------------------------------------------
`default_nettype none
module sck_queue #(
    parameter int Depth = sck_pkg::QueueDepth
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           wr_valid,
    output logic                wr_ready,
    input  wire sck_pkg::item_t wr_item,
    output logic                rd_valid,
    input  wire logic           rd_ready,
    output sck_pkg::item_t      rd_item
);
    localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
    sck_pkg::item_t mem_reg [Depth];
    logic [AW-1:0] wp_reg, rp_reg;
    logic [AW:0]   cnt_reg;
    logic          do_wr, do_rd;

    assign wr_ready = (cnt_reg != (AW+1)'(Depth));
    assign rd_valid = (cnt_reg != '0);
    assign rd_item  = mem_reg[rp_reg];
    assign do_wr = wr_valid && wr_ready;
    assign do_rd = rd_valid && rd_ready;

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wp_reg] <= wr_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (do_wr)
                wp_reg <= (wp_reg == AW'(Depth - 1)) ? '0 : wp_reg + 1'b1;
            if (do_rd)
                rp_reg <= (rp_reg == AW'(Depth - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (AW+1)'(do_wr) - (AW+1)'(do_rd);
        end
    end
endmodule
`default_nettype wire

// ----- rtl/sck_core.sv -----
// ----------------------------------------------------------------------------
// sck_core
// Iterative SHA-256 compression, one round a cycle, and the byte XOR output.
// ----------------------------------------------------------------------------
`default_nettype none
module sck_core (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic [255:0]   key,
    input  wire logic [127:0]   nonce,
    input  wire logic           q_valid,
    output logic                q_ready,
    input  wire sck_pkg::item_t q_item,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [7:0]          out_byte,
    output logic                out_last
);
    sck_pkg::core_state_t state_reg, state_next;
    logic [31:0] w_reg [16];
    logic [31:0] v_reg [8];
    logic [255:0] ks_reg;
    logic [5:0]  rnd_reg;
    logic [7:0]  ob_reg;
    logic        ol_reg, ov_reg;
    logic        take, emit, out_free, start_hash;
    logic [31:0] w_new, t1, t2, s0, s1, wcur;
    logic [255:0] digest;
    logic [7:0]  ks_byte;

    // Take a word only when the output register is free this cycle: a new block
    // parks its byte in the output register while it is hashed.
    assign out_free = !ov_reg || out_ready;
    assign q_ready  = (state_reg == sck_pkg::ST_IDLE) && out_free;
    assign take       = q_valid && q_ready;
    assign start_hash = take && q_item.new_block;
    assign emit       = (state_reg == sck_pkg::ST_OUT && out_free)
                      || (take && !q_item.new_block);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sck_pkg::ST_IDLE:  if (start_hash) state_next = sck_pkg::ST_ROUND;
            sck_pkg::ST_ROUND: if (rnd_reg == 6'd63) state_next = sck_pkg::ST_OUT;
            sck_pkg::ST_OUT:   if (out_free) state_next = sck_pkg::ST_IDLE;
            default:           state_next = sck_pkg::ST_IDLE;
        endcase
    end

    // Round datapath.
    assign wcur = w_reg[0];
    assign s0 = sck_pkg::rotr(w_reg[1], 7) ^ sck_pkg::rotr(w_reg[1], 18) ^ (w_reg[1] >> 3);
    assign s1 = sck_pkg::rotr(w_reg[14], 17) ^ sck_pkg::rotr(w_reg[14], 19) ^ (w_reg[14] >> 10);
    assign w_new = w_reg[0] + s0 + w_reg[9] + s1;
    assign t1 = v_reg[7] + (sck_pkg::rotr(v_reg[4], 6) ^ sck_pkg::rotr(v_reg[4], 11)
              ^ sck_pkg::rotr(v_reg[4], 25)) + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + sck_pkg::RoundK[rnd_reg] + wcur;
    assign t2 = (sck_pkg::rotr(v_reg[0], 2) ^ sck_pkg::rotr(v_reg[0], 13)
              ^ sck_pkg::rotr(v_reg[0], 22))
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    always_comb
    begin
        for (int i = 0; i < 8; i++)
            digest[255 - 32*i -: 32] = sck_pkg::InitH[i] + v_reg[i];
    end

    assign ks_byte = ks_reg[255 - 8*q_item.pos -: 8];

    always_ff @(posedge clk)
    begin
        if (start_hash)
        begin
            for (int i = 0; i < 8; i++)
                w_reg[i] <= key[255 - 32*i -: 32];
            for (int i = 0; i < 4; i++)
                w_reg[8+i] <= nonce[127 - 32*i -: 32];
            w_reg[12] <= q_item.count;
            w_reg[13] <= 32'h80000000;
            w_reg[14] <= 32'd0;
            w_reg[15] <= 32'd416;
            for (int i = 0; i < 8; i++)
                v_reg[i] <= sck_pkg::InitH[i];
            ob_reg <= q_item.data_byte;
            ol_reg <= q_item.last;
        end
        else if (state_reg == sck_pkg::ST_ROUND)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i+1];
            w_reg[15] <= w_new;
            v_reg[7] <= v_reg[6]; v_reg[6] <= v_reg[5]; v_reg[5] <= v_reg[4];
            v_reg[4] <= v_reg[3] + t1;
            v_reg[3] <= v_reg[2]; v_reg[2] <= v_reg[1]; v_reg[1] <= v_reg[0];
            v_reg[0] <= t1 + t2;
        end
        if (state_reg == sck_pkg::ST_OUT && out_free)
        begin
            ks_reg <= digest;
            ob_reg <= ob_reg ^ digest[255:248];
        end
        else if (take && !q_item.new_block)
        begin
            ob_reg <= q_item.data_byte ^ ks_byte;
            ol_reg <= q_item.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sck_pkg::ST_IDLE;
            rnd_reg   <= 6'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= (state_reg == sck_pkg::ST_ROUND) ? rnd_reg + 6'd1 : 6'd0;
            if (emit)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    assign out_valid = ov_reg;
    assign out_byte  = ob_reg;
    assign out_last  = ol_reg;
endmodule
`default_nettype wire

// ----- rtl/sha256_ctr_keystream_xor_top.sv -----
// Throughput: one byte a cycle within a block while the output is ready; a new 32-byte block
// costs one 64-round compression on the shared round unit, during which no byte is taken.
// Reset: rst_n asynchronous, active low; clears counter, position, queue and handshake
// state; key and nonce registers reset to zero.
// ----------------------------------------------------------------------------
// sha256_ctr_keystream_xor_top
// SHA-256 counter-mode keystream XOR over a byte stream.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_ctr_keystream_xor_top #(
    parameter int QueueDepth = sck_pkg::QueueDepth
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  wire logic        s_axis_tlast,   // msg_end
    input  wire logic        s_axis_tuser,   // msg_start
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [7:0] out_byte
    output logic             m_axis_tlast,   // out_last
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);
    logic [63:0] regs_reg [6];
    logic fq_valid, fq_ready, cq_valid, cq_ready;
    sck_pkg::item_t fq_item, cq_item;

    // Configuration is always accepted; unknown indexes are dropped.
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            for (int i = 0; i < 6; i++) regs_reg[i] <= 64'd0;
        else if (cfg_valid)
        begin
            case (cfg_index)
                sck_pkg::RegKeyW0:   regs_reg[0] <= cfg_data;
                sck_pkg::RegKeyW1:   regs_reg[1] <= cfg_data;
                sck_pkg::RegKeyW2:   regs_reg[2] <= cfg_data;
                sck_pkg::RegKeyW3:   regs_reg[3] <= cfg_data;
                sck_pkg::RegNonceHi: regs_reg[4] <= cfg_data;
                sck_pkg::RegNonceLo: regs_reg[5] <= cfg_data;
                default: ;
            endcase
        end
    end

    sck_front u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .data_byte(s_axis_tdata), .msg_start(s_axis_tuser), .msg_end(s_axis_tlast),
        .q_valid(fq_valid), .q_ready(fq_ready), .q_item(fq_item));

    sck_queue #(.Depth(QueueDepth)) u_queue (
        .clk, .rst_n,
        .wr_valid(fq_valid), .wr_ready(fq_ready), .wr_item(fq_item),
        .rd_valid(cq_valid), .rd_ready(cq_ready), .rd_item(cq_item));

    sck_core u_core (
        .clk, .rst_n,
        .key({regs_reg[0], regs_reg[1], regs_reg[2], regs_reg[3]}),
        .nonce({regs_reg[4], regs_reg[5]}),
        .q_valid(cq_valid), .q_ready(cq_ready), .q_item(cq_item),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_byte(m_axis_tdata), .out_last(m_axis_tlast));
endmodule
`default_nettype wire

// ----- rtl/sck_checker.sv -----
// ----------------------------------------------------------------------------
// sck_checker
// Port-level checks on the keystream block.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha256_ctr_keystream_xor_top_assert.svh"
module sck_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata,
    input wire logic       m_axis_tlast,
    input wire logic       cfg_ready
);
    `SCK_ASSERT(a_hold_valid, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid, "valid dropped")
    `SCK_HOLD_STABLE(a_hold_data, m_axis_tdata, "data moved")
    `SCK_HOLD_STABLE(a_hold_last, m_axis_tlast, "last moved")
    `SCK_ASSERT(a_cfg_ready, 1'b1 |-> cfg_ready, "cfg stalled")
endmodule
bind sha256_ctr_keystream_xor_top sck_checker u_chk (.*);
`default_nettype wire

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Keystream XOR bench
// Streams messages of random length and content through the SHA-256
// counter-mode XOR block, predicts every output byte with its own digest
// model and checks byte and last flag in order under random stalls.
// ----------------------------------------------------------------------------

class keystream_scoreboard;
    logic [63:0] key_nonce [6];
    logic [31:0] blk_ctr;
    logic [4:0]  pos;
    logic [7:0]  pad [32];
    logic [8:0]  pending [$];
    int          errors;

    function new();
        foreach (key_nonce[i]) key_nonce[i] = '0;
        blk_ctr = '0;
        pos = '0;
        errors = 0;
    endfunction

    function automatic logic [31:0] ror(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    function void make_pad();
        logic [31:0] k [64];
        logic [31:0] h0 [8];
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2, s0, s1, hsum;
        k = '{
            32'h428a2f98,32'h71374491,32'hb5c0fbcf,32'he9b5dba5,32'h3956c25b,32'h59f111f1,
            32'h923f82a4,32'hab1c5ed5,32'hd807aa98,32'h12835b01,32'h243185be,32'h550c7dc3,
            32'h72be5d74,32'h80deb1fe,32'h9bdc06a7,32'hc19bf174,32'he49b69c1,32'hefbe4786,
            32'h0fc19dc6,32'h240ca1cc,32'h2de92c6f,32'h4a7484aa,32'h5cb0a9dc,32'h76f988da,
            32'h983e5152,32'ha831c66d,32'hb00327c8,32'hbf597fc7,32'hc6e00bf3,32'hd5a79147,
            32'h06ca6351,32'h14292967,32'h27b70a85,32'h2e1b2138,32'h4d2c6dfc,32'h53380d13,
            32'h650a7354,32'h766a0abb,32'h81c2c92e,32'h92722c85,32'ha2bfe8a1,32'ha81a664b,
            32'hc24b8b70,32'hc76c51a3,32'hd192e819,32'hd6990624,32'hf40e3585,32'h106aa070,
            32'h19a4c116,32'h1e376c08,32'h2748774c,32'h34b0bcb5,32'h391c0cb3,32'h4ed8aa4a,
            32'h5b9cca4f,32'h682e6ff3,32'h748f82ee,32'h78a5636f,32'h84c87814,32'h8cc70208,
            32'h90befffa,32'ha4506ceb,32'hbef9a3f7,32'hc67178f2};
        h0 = '{32'h6a09e667,32'hbb67ae85,32'h3c6ef372,32'ha54ff53a,
               32'h510e527f,32'h9b05688c,32'h1f83d9ab,32'h5be0cd19};
        for (int i = 0; i < 6; i++)
        begin
            w[2*i]   = key_nonce[i][63:32];
            w[2*i+1] = key_nonce[i][31:0];
        end
        w[12] = blk_ctr;
        w[13] = 32'h80000000;
        w[14] = '0;
        w[15] = 32'd416;
        for (int i = 16; i < 64; i++)
        begin
            s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
            s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
            w[i] = w[i-16] + s0 + w[i-7] + s1;
        end
        v = h0;
        for (int i = 0; i < 64; i++)
        begin
            t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + k[i] + w[i];
            t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++)
        begin
            hsum = h0[i] + v[i];
            {pad[4*i], pad[4*i+1], pad[4*i+2], pad[4*i+3]} = hsum;
        end
    endfunction

    function void note_input(logic [7:0] data, logic start, logic last);
        if (start)
        begin
            blk_ctr = '0;
            pos = '0;
        end
        if (pos == 0)
            make_pad();
        pending.push_back({last, data ^ pad[pos]});
        if (last)
        begin
            pos = '0;
            blk_ctr = '0;
        end
        else
        begin
            pos = pos + 1'b1;
            if (pos == 0)
                blk_ctr = blk_ctr + 1;
        end
    endfunction

    function void check_output(logic [7:0] data, logic last);
        logic [8:0] want;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected byte, expected none, actual %h last %b",
                     $time, data, last);
            errors++;
            return;
        end
        want = pending.pop_front();
        if (want[7:0] !== data)
        begin
            $display("%0t: out_byte expected %h actual %h", $time, want[7:0], data);
            errors++;
        end
        if (want[8] !== last)
        begin
            $display("%0t: out_last expected %b actual %b", $time, want[8], last);
            errors++;
        end
    endfunction
endclass

module testbench;
    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // msg_end
    logic        s_axis_tuser;   // msg_start
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [7:0]  m_axis_tdata;   // [7:0] out_byte
    logic        m_axis_tlast;   // out_last
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [63:0] cfg_data;

    keystream_scoreboard sb;
    int burst_left;
    int stall_mode;
    int bytes_sent;

    sha256_ctr_keystream_xor_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Generous ceiling: ~1700 bytes, including hashing and stalls.
    initial
    begin
        #200ms;
        $display("FAIL sha256_ctr_keystream_xor_top");
        $finish;
    end

    // Output side: sample at the rising edge, change ready at the falling edge.
    // The stall pattern switches between always-ready, light and heavy stalling.
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_output(m_axis_tdata, m_axis_tlast);

    always @(negedge clk)
    begin
        if ($urandom_range(0, 99) == 0)
            stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // Register write while the block is idle; the prediction follows at once.
    task automatic write_reg(logic [2:0] idx, logic [63:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        sb.key_nonce[idx] = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Send one word; hold valid across back-to-back words of a burst.
    task automatic send_byte(logic [7:0] data, logic start, logic last);
        if (burst_left == 0)
        begin
            repeat ($urandom_range(1, 6)) @(negedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 12);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tuser  <= start;
        s_axis_tlast  <= last;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_input(data, start, last);
        bytes_sent++;
        burst_left--;
        @(negedge clk);
        if (burst_left == 0)
            s_axis_tvalid <= 1'b0;
    endtask

    task automatic send_message(int len, bit with_start);
        for (int i = 0; i < len; i++)
            send_byte($urandom_range(0, 255), with_start && i == 0, i == len - 1);
    endtask

    // Drain expectations, then allow a full compression before touching registers.
    // Drop a held valid at once so the last word is not taken twice.
    task automatic drain();
        if (burst_left != 0)
            s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    task automatic load_all(logic [63:0] fill, bit rnd);
        for (int r = 0; r < 6; r++)
            write_reg(r[2:0], rnd ? {$urandom, $urandom} : fill);
    endtask

    initial
    begin
        int len;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = 1'b0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b1;
        cfg_valid = 1'b0;
        cfg_index = sck_pkg::RegKeyW0;
        cfg_data = '0;
        burst_left = 0;
        stall_mode = 0;
        bytes_sent = 0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: all-zero key, extreme bytes, one-byte message.
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hff, 1'b1, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hff, 1'b0, 1'b1);
        // bytes after an end without start act as a new message
        send_byte(8'h5a, 1'b0, 1'b1);
        drain();
        load_all(64'hffff_ffff_ffff_ffff, 1'b0);
        send_message(20, 1'b1);
        // a start in the middle of a message restarts block position and counter
        send_byte(8'ha5, 1'b1, 1'b0);
        send_byte(8'h3c, 1'b1, 1'b1);
        drain();
        write_reg(sck_pkg::RegKeyW0, 64'h0123_4567_89ab_cdef);
        write_reg(sck_pkg::RegNonceLo, 64'h0);

        // Random: mostly well-formed messages, some crossing several blocks,
        // some broken by a restart or missing start; rekey between phases.
        for (int phase = 0; phase < 8; phase++)
        begin
            while (bytes_sent < 200 * (phase + 1))
            begin
                case ($urandom_range(0, 9))
                    0: len = $urandom_range(33, 100);
                    1: send_byte($urandom_range(0, 255), $urandom_range(0, 1),
                                 $urandom_range(0, 1));
                    2: send_message($urandom_range(1, 40), 1'b0);
                    default: len = $urandom_range(1, 40);
                endcase
                send_message(len, 1'b1);
                len = 0;
            end
            drain();
            if (phase == 3)
                load_all(64'h0, 1'b0);
            else
                load_all(64'h0, 1'b1);
        end
        drain();

        if (sb.errors == 0)
            $display("PASS sha256_ctr_keystream_xor_top");
        else
            $display("FAIL sha256_ctr_keystream_xor_top");
        $finish;
    end
endmodule
